[hw/rtl/homography_point_projector_macros.svh]
// Assertion macros shared by the homography point projector RTL.
`ifndef HOMOGRAPHY_POINT_PROJECTOR_MACROS_SVH
`define HOMOGRAPHY_POINT_PROJECTOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define HPP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define HPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HPP_ASSERT_SAME(lbl, ante, cons, msg)
`define HPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/hpp_pkg.sv]
// Types and constants for the homography point projector.
package hpp_pkg;

	localparam int CoefW  = 21;
	localparam int PointW = 16;
	localparam int RowW   = 63;
	localparam int ProdW  = CoefW + PointW;  // 37-bit signed product
	localparam int SumW   = ProdW + 1;       // 38-bit signed dot product
	localparam int MagW   = SumW - 1;        // magnitude of a dot product
	localparam int NumW   = MagW + 6;        // 32*|n| + |w|
	localparam int DivW   = MagW + 1;        // 2*|w|
	localparam int QuoW   = 24;              // quotient bits, one per cell
	localparam int OutW   = 24;

	localparam logic [1:0] CFG_ROW_X = 2'd0;
	localparam logic [1:0] CFG_ROW_Y = 2'd1;
	localparam logic [1:0] CFG_ROW_W = 2'd2;

	localparam logic [OutW-1:0] OUT_POS_MAX = 24'h7FFFFF;
	localparam logic [OutW-1:0] OUT_NEG_MIN = 24'h800000;

	// Partial state of one division lane as it walks down the cell chain
	typedef struct packed {
		logic [DivW-1:0] rem;
		logic [QuoW-1:0] nrest;
		logic [QuoW-1:0] quo;
		logic [DivW-1:0] dvs;
	} div_lane_t;

	// Per-beat control that travels alongside the division lanes
	typedef struct packed {
		logic vld;
		logic deg;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} beat_ctrl_t;

endpackage

[hw/rtl/homography_point_projector.sv]
// Top level of the homography point projector: multiply, sum, divide chain, output.
//
// Projects a signed Q12.4 point (point_x, point_y) through a 3x3 homography
// held in three 63-bit row registers, giving signed Q20.4 results.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 = x row, 1 = y row,
// 2 = w row, 3 ignored) and cfg_data; cfg_ready is always high. Rows must be
// written only while the block is idle; the block itself does not enforce this.
// Input channel: in_valid/in_stall carry point_x, point_y.
// Output channel: out_valid/out_stall carry proj_x, proj_y, degenerate, saturated.
// Throughput: one point per cycle while out_stall does not hold the pipeline. An
// accepted beat passes the input register, the multiply, sum and chain-entry stages,
// 24 divider cells (one quotient bit each) and the output register to out_valid.
// When the receiver stalls with a result held, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped.
// Reset clears all valid bits and loads the identity matrix (COEF_FRAC 15).
// A zero divisor gives (0,0) with degenerate set; overflowing quotients are
// clamped to the Q20.4 range with saturated set.
`include "homography_point_projector_macros.svh"
module homography_point_projector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [62:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  point_x,
	input  logic signed [15:0]  point_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [23:0]  proj_x,
	output logic signed [23:0]  proj_y,
	output logic                degenerate,
	output logic                saturated
);
	import hpp_pkg::*;

	logic [RowW-1:0] row_x_q, row_y_q, row_w_q;
	logic            adv;

	// Config registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q <= 63'd1 << 15;
			row_y_q <= 63'd1 << 36;
			row_w_q <= 63'd1 << 57;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_X: row_x_q <= cfg_data;
				CFG_ROW_Y: row_y_q <= cfg_data;
				CFG_ROW_W: row_w_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Global advance: pipeline moves when the output register can take a beat
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Valid bits for the front stages
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: input register
	logic signed [PointW-1:0] px_s1, py_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= point_x;
			py_s1 <= point_y;
		end
	end

	// Coefficient slices
	function automatic logic signed [CoefW-1:0] coef(input logic [RowW-1:0] row,
		input logic [1:0] slot);
		logic signed [CoefW-1:0] c;
		begin
			case (slot)
				2'd0:    c = row[20:0];
				2'd1:    c = row[41:21];
				default: c = row[62:42];
			endcase
			return c;
		end
	endfunction

	// Stage 2: six products and the three constant coefficients
	logic signed [ProdW-1:0] mxx_s2, mxy_s2, myx_s2, myy_s2, mwx_s2, mwy_s2;
	logic signed [CoefW-1:0] cx_s2, cy_s2, cw_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			mxx_s2 <= coef(row_x_q, 2'd0) * px_s1;
			mxy_s2 <= coef(row_x_q, 2'd1) * py_s1;
			myx_s2 <= coef(row_y_q, 2'd0) * px_s1;
			myy_s2 <= coef(row_y_q, 2'd1) * py_s1;
			mwx_s2 <= coef(row_w_q, 2'd0) * px_s1;
			mwy_s2 <= coef(row_w_q, 2'd1) * py_s1;
			cx_s2  <= coef(row_x_q, 2'd2);
			cy_s2  <= coef(row_y_q, 2'd2);
			cw_s2  <= coef(row_w_q, 2'd2);
		end
	end

	function automatic logic signed [SumW-1:0] dot3(input logic signed [ProdW-1:0] a,
		input logic signed [ProdW-1:0] b, input logic signed [CoefW-1:0] c);
		logic signed [SumW-1:0] ea, eb, ec;
		begin
			ea = {a[ProdW-1], a};
			eb = {b[ProdW-1], b};
			ec = {{(SumW-CoefW-4){c[CoefW-1]}}, c, 4'b0000};
			return ea + eb + ec;
		end
	endfunction

	// Stage 3: dot products
	logic signed [SumW-1:0] nx_s3, ny_s3, w_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3 <= dot3(mxx_s2, mxy_s2, cx_s2);
			ny_s3 <= dot3(myx_s2, myy_s2, cy_s2);
			w_s3  <= dot3(mwx_s2, mwy_s2, cw_s2);
		end
	end

	// Magnitudes, rounding numerator, divisor and overflow pre-check
	logic [MagW-1:0] anx, any_m, aw;
	logic [NumW-1:0] numx, numy;
	logic [DivW-1:0] dvs;
	logic            ovfx, ovfy;
	always_comb begin
		anx   = nx_s3[SumW-1] ? MagW'(-nx_s3) : MagW'(nx_s3);
		any_m = ny_s3[SumW-1] ? MagW'(-ny_s3) : MagW'(ny_s3);
		aw    = w_s3[SumW-1]  ? MagW'(-w_s3)  : MagW'(w_s3);
		numx  = {anx, 5'b00000} + {6'b000000, aw};
		numy  = {any_m, 5'b00000} + {6'b000000, aw};
		dvs   = {aw, 1'b0};
		ovfx  = {19'd0, numx} >= {dvs, 24'd0};
		ovfy  = {19'd0, numy} >= {dvs, 24'd0};
	end

	// Stage 4: chain entry
	div_lane_t  lane_x [0:QuoW];
	div_lane_t  lane_y [0:QuoW];
	beat_ctrl_t ctrl_q [0:QuoW];
	always_ff @(posedge clk) begin
		if (adv) begin
			lane_x[0] <= '{rem: DivW'(numx[NumW-1:QuoW]), nrest: numx[QuoW-1:0],
				quo: '0, dvs: dvs};
			lane_y[0] <= '{rem: DivW'(numy[NumW-1:QuoW]), nrest: numy[QuoW-1:0],
				quo: '0, dvs: dvs};
		end
	end

	// Control shift line beside the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QuoW; i++) begin
				ctrl_q[i] <= '0;
			end
		end else if (adv) begin
			ctrl_q[0] <= '{vld: vld_s3, deg: (w_s3 == '0),
				neg_x: nx_s3[SumW-1] ^ w_s3[SumW-1],
				neg_y: ny_s3[SumW-1] ^ w_s3[SumW-1], ovf_x: ovfx, ovf_y: ovfy};
			for (int i = 1; i <= QuoW; i++) begin
				ctrl_q[i] <= ctrl_q[i-1];
			end
		end
	end
	assign vld_s4 = ctrl_q[0].vld;

	// Divider cell chains, one quotient bit per cell
	for (genvar g = 0; g < QuoW; g++) begin : g_cell
		hpp_div_cell u_cx (.clk(clk), .en(adv), .lane_in(lane_x[g]), .lane_out(lane_x[g+1]));
		hpp_div_cell u_cy (.clk(clk), .en(adv), .lane_in(lane_y[g]), .lane_out(lane_y[g+1]));
	end

	// Sign, saturation and zero-divisor handling
	beat_ctrl_t      fin;
	logic [QuoW-1:0] qx, qy;
	logic            satx, saty;
	logic [OutW-1:0] rx, ry;
	always_comb begin
		fin  = ctrl_q[QuoW];
		qx   = lane_x[QuoW].quo;
		qy   = lane_y[QuoW].quo;
		satx = fin.ovf_x || (fin.neg_x ? (qx[23] && (qx[22:0] != '0)) : qx[23]);
		saty = fin.ovf_y || (fin.neg_y ? (qy[23] && (qy[22:0] != '0)) : qy[23]);
		if (fin.deg) begin
			rx = '0;
			ry = '0;
		end else begin
			rx = satx ? (fin.neg_x ? OUT_NEG_MIN : OUT_POS_MAX) : (fin.neg_x ? -qx : qx);
			ry = saty ? (fin.neg_y ? OUT_NEG_MIN : OUT_POS_MAX) : (fin.neg_y ? -qy : qy);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= fin.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			proj_x     <= rx;
			proj_y     <= ry;
			degenerate <= fin.deg;
			saturated  <= !fin.deg && (satx || saty);
		end
	end

	`HPP_ASSERT_SAME(a_deg_zero, out_valid && degenerate,
		!saturated && proj_x == '0 && proj_y == '0, "degenerate beat not zeroed")
	`HPP_ASSERT_NEXT(a_accept_s1, in_valid && !in_stall, vld_s1,
		"accepted beat missing from stage 1")
	`HPP_ASSERT_NEXT(a_freeze, !adv && arst_n, $stable(vld_s4) && $stable(ctrl_q[QuoW].vld),
		"pipeline moved while frozen")
	`HPP_ASSERT_SAME(a_stall_rule, out_valid && out_stall, in_stall,
		"input taken while output blocked")

endmodule

[hw/rtl/hpp_div_cell.sv]
// One restoring-division cell: retires one quotient bit per beat.
module hpp_div_cell (
	input  logic               clk,
	input  logic               en,
	input  hpp_pkg::div_lane_t lane_in,
	output hpp_pkg::div_lane_t lane_out
);
	import hpp_pkg::*;

	logic [DivW:0]   trial;
	logic [DivW:0]   diff;
	logic            take;
	div_lane_t       nxt;

	// Shift the next numerator bit into the remainder and try a subtract
	always_comb begin
		trial = {lane_in.rem, lane_in.nrest[QuoW-1]};
		diff  = trial - {1'b0, lane_in.dvs};
		take  = !diff[DivW];
		nxt.rem   = take ? diff[DivW-1:0] : trial[DivW-1:0];
		nxt.nrest = {lane_in.nrest[QuoW-2:0], 1'b0};
		nxt.quo   = {lane_in.quo[QuoW-2:0], take};
		nxt.dvs   = lane_in.dvs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out <= nxt;
		end
	end

endmodule
